@@ rtl/vrt_pkg.sv @@
// ----------------------------------------------------------------------------
// vrt_pkg: shared types and constants of the voxel ray traversal block
// Payload structs, fixed-point widths, divider operand codes and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package vrt_pkg;

   // run limit and t fraction width
   localparam int MAX_VOXELS  = 64;
   localparam int T_FRAC_BITS = 32;

   // t values: 16 integer bits and T_FRAC_BITS fraction bits
   localparam int TW = 16 + T_FRAC_BITS;
   localparam logic [TW-1:0] TMAX = '1;

   // divider: 33-bit numerator scaled by 2^T_FRAC_BITS over a 33-bit divisor
   localparam int DIV_W = 33;
   localparam int DVD_W = DIV_W + T_FRAC_BITS;
   localparam int DCNT_W = $clog2(DVD_W + 1);

   // voxel counter
   localparam int CNT_W = (MAX_VOXELS > 2) ? $clog2(MAX_VOXELS) : 1;

   // voxel size register
   localparam int SIZE_W = 31;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 31'd6554;

   // divider operand select
   localparam logic [1:0] DSEL_START = 2'd0;
   localparam logic [1:0] DSEL_END   = 2'd1;
   localparam logic [1:0] DSEL_NEXT  = 2'd2;
   localparam logic [1:0] DSEL_DELTA = 2'd3;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] end_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] index_x;
      logic signed [31:0] index_y;
      logic signed [31:0] index_z;
      logic signed [31:0] corner_x;
      logic signed [31:0] corner_y;
      logic signed [31:0] corner_z;
      logic               last;
      logic               truncated;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       div_start;
      logic [1:0] div_sel;
      logic [1:0] axis;
      logic       wr_start_idx;
      logic       wr_end_idx;
      logic       wr_tnext;
      logic       wr_tdelta;
      logic       mul_bound;
      logic       calc_num;
      logic       mul_corner;
      logic       sat_corner;
      logic       advance;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic last;
   } status_type;

endpackage

@@ rtl/vrt_div.sv @@
// ----------------------------------------------------------------------------
// vrt_div: restoring unsigned divider
// One quotient bit per cycle; quotient shifts into the dividend register.
// ----------------------------------------------------------------------------
module vrt_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [vrt_pkg::DVD_W-1:0]   dividend,
   input  logic [vrt_pkg::DIV_W-1:0]   divisor,
   output logic                        busy,
   output logic [vrt_pkg::DVD_W-1:0]   quotient,
   output logic                        rem_nz
);

   logic [vrt_pkg::DVD_W-1:0]  dvd_ff;
   logic [vrt_pkg::DIV_W-1:0]  rem_ff;
   logic [vrt_pkg::DIV_W-1:0]  dsr_ff;
   logic [vrt_pkg::DCNT_W-1:0] cnt_ff;
   logic                       busy_ff;
   logic [vrt_pkg::DIV_W:0]    rem_sh;
   logic [vrt_pkg::DIV_W:0]    rem_sub;
   logic                       ge;

   // one trial subtract per cycle
   assign rem_sh  = {rem_ff, dvd_ff[vrt_pkg::DVD_W-1]};
   assign ge      = rem_sh >= {1'b0, dsr_ff};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};

   // iteration control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= vrt_pkg::DCNT_W'(vrt_pkg::DVD_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == vrt_pkg::DCNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // remainder and quotient shift
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[vrt_pkg::DVD_W-2:0], ge};
         rem_ff <= ge ? rem_sub[vrt_pkg::DIV_W-1:0] : rem_sh[vrt_pkg::DIV_W-1:0];
      end
   end

   assign busy     = busy_ff;
   assign quotient = dvd_ff;
   assign rem_nz   = (rem_ff != '0);

endmodule

@@ rtl/vrt_dp.sv @@
// ----------------------------------------------------------------------------
// vrt_dp: traversal datapath
// Holds the ray, per-axis walk state and the voxel size register; owns the
// shared multiplier and feeds the divider.
// ----------------------------------------------------------------------------
module vrt_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  vrt_pkg::cmd_type            cmd,
   output vrt_pkg::status_type         status,
   input  vrt_pkg::req_type            req_data,
   output vrt_pkg::rsp_type            rsp_data,
   input  logic                        csr_wr_en,
   input  logic [vrt_pkg::SIZE_W-1:0]  csr_wr_data,
   output logic                        div_start,
   output logic [vrt_pkg::DVD_W-1:0]   div_dividend,
   output logic [vrt_pkg::DIV_W-1:0]   div_divisor,
   input  logic                        div_busy,
   input  logic [vrt_pkg::DVD_W-1:0]   div_quotient,
   input  logic                        div_rem_nz
);

   logic [vrt_pkg::SIZE_W-1:0] csr_size_ff;
   logic [vrt_pkg::SIZE_W-1:0] sz_ff;
   vrt_pkg::req_type           in_ff;
   logic [31:0]                cur_ff    [3];
   logic [31:0]                endv_ff   [3];
   logic [vrt_pkg::TW-1:0]     tn_ff     [3];
   logic [vrt_pkg::TW-1:0]     td_ff     [3];
   logic [31:0]                corner_ff [3];
   logic [2:0]                 neg_ff;
   logic [2:0]                 diff_ff;
   logic                       pre_ff;
   logic [vrt_pkg::CNT_W-1:0]  cnt_ff;
   logic signed [63:0]         prod_ff;
   logic [32:0]                un_ff;

   logic signed [31:0] s_sel;
   logic signed [31:0] e_sel;
   logic signed [32:0] r_sel;
   logic [32:0]        ur;
   logic               rzero;
   logic               rneg;
   logic [32:0]        abs_s;
   logic [32:0]        abs_e;
   logic [32:0]        q33;
   logic [32:0]        qf;
   logic [32:0]        fl_pos;
   logic [32:0]        fl_neg;
   logic [31:0]        ci_s;
   logic [31:0]        ci_e;
   logic [vrt_pkg::TW-1:0] tq;
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] mul_p;
   logic signed [63:0] num;
   logic [63:0]        num_abs;
   logic [31:0]        sat_val;
   logic               at_end;
   logic               cap;
   logic [1:0]         ax_adv;
   logic [vrt_pkg::TW:0] tsum;

   // voxel size register, zero acts as one
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_size_ff <= vrt_pkg::SIZE_RESET;
      end else if (csr_wr_en) begin
         csr_size_ff <= csr_wr_data;
      end
   end

   // per-axis operand select
   always_comb begin
      case (cmd.axis)
         2'd1: begin
            s_sel = in_ff.start_y;
            e_sel = in_ff.end_y;
         end
         2'd2: begin
            s_sel = in_ff.start_z;
            e_sel = in_ff.end_z;
         end
         default: begin
            s_sel = in_ff.start_x;
            e_sel = in_ff.end_x;
         end
      endcase
   end

   assign r_sel = $signed({e_sel[31], e_sel}) - $signed({s_sel[31], s_sel});
   assign rneg  = r_sel[32];
   assign rzero = (r_sel == '0);
   assign ur    = rneg ? 33'(-r_sel) : 33'(r_sel);
   assign abs_s = s_sel[31] ? 33'(-$signed({s_sel[31], s_sel})) : {1'b0, s_sel};
   assign abs_e = e_sel[31] ? 33'(-$signed({e_sel[31], e_sel})) : {1'b0, e_sel};

   // divider operands
   always_comb begin
      case (cmd.div_sel)
         vrt_pkg::DSEL_START: begin
            div_dividend = vrt_pkg::DVD_W'(abs_s);
            div_divisor  = {2'b00, sz_ff};
         end
         vrt_pkg::DSEL_END: begin
            div_dividend = vrt_pkg::DVD_W'(abs_e);
            div_divisor  = {2'b00, sz_ff};
         end
         vrt_pkg::DSEL_NEXT: begin
            div_dividend = {un_ff, {vrt_pkg::T_FRAC_BITS{1'b0}}};
            div_divisor  = ur;
         end
         default: begin
            div_dividend = {2'b00, sz_ff, {vrt_pkg::T_FRAC_BITS{1'b0}}};
            div_divisor  = ur;
         end
      endcase
   end
   assign div_start = cmd.div_start;

   // floor division fixup
   assign q33    = div_quotient[32:0];
   assign qf     = q33 + {32'd0, div_rem_nz};
   assign fl_pos = q33;
   assign fl_neg = 33'(-qf);
   assign ci_s   = s_sel[31] ? fl_neg[31:0] : fl_pos[31:0];
   assign ci_e   = e_sel[31] ? fl_neg[31:0] : fl_pos[31:0];

   // t quotient saturation
   assign tq = (rzero || (div_quotient[vrt_pkg::DVD_W-1:vrt_pkg::TW] != '0)) ?
               vrt_pkg::TMAX : div_quotient[vrt_pkg::TW-1:0];

   // shared multiplier: boundary or corner
   always_comb begin
      mul_a = $signed({cur_ff[cmd.axis][31], cur_ff[cmd.axis]});
      if (cmd.mul_bound) begin
         mul_a = rneg ? mul_a - 33'sd1 : mul_a + 33'sd1;
      end
   end
   assign mul_b = $signed({2'b00, sz_ff});
   assign mul_p = mul_a * mul_b;

   // boundary distance and corner saturation
   assign num     = prod_ff - 64'(s_sel);
   assign num_abs = num[63] ? 64'(-num) : 64'(num);
   always_comb begin
      if (prod_ff > 64'sd2147483647) begin
         sat_val = 32'h7FFF_FFFF;
      end else if (prod_ff < -64'sd2147483648) begin
         sat_val = 32'h8000_0000;
      end else begin
         sat_val = prod_ff[31:0];
      end
   end

   // axis choice, ties favor z then y
   always_comb begin
      if (tn_ff[0] < tn_ff[1]) begin
         ax_adv = (tn_ff[0] < tn_ff[2]) ? 2'd0 : 2'd2;
      end else begin
         ax_adv = (tn_ff[1] < tn_ff[2]) ? 2'd1 : 2'd2;
      end
   end
   assign tsum = {1'b0, tn_ff[ax_adv]} + {1'b0, td_ff[ax_adv]};

   // run end checks
   assign at_end = (cur_ff[0] == endv_ff[0]) && (cur_ff[1] == endv_ff[1]) &&
                   (cur_ff[2] == endv_ff[2]);
   assign cap    = (cnt_ff == vrt_pkg::CNT_W'(vrt_pkg::MAX_VOXELS - 1));

   // walk control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (cmd.load) begin
         pre_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (cmd.wr_end_idx && (cur_ff[cmd.axis] != ci_e) && rneg) begin
            pre_ff <= 1'b1;
         end
         if (cmd.advance) begin
            pre_ff <= 1'b0;
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // ray and axis payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_ff <= req_data;
         sz_ff <= (csr_size_ff == '0) ? vrt_pkg::SIZE_W'(1) : csr_size_ff;
      end
      if (cmd.wr_start_idx) begin
         cur_ff[cmd.axis] <= ci_s;
      end
      if (cmd.wr_end_idx) begin
         endv_ff[cmd.axis] <= ci_e;
         neg_ff[cmd.axis]  <= rneg;
         diff_ff[cmd.axis] <= (cur_ff[cmd.axis] != ci_e) && rneg;
      end
      if (cmd.mul_bound || cmd.mul_corner) begin
         prod_ff <= mul_p[63:0];
      end
      if (cmd.calc_num) begin
         un_ff <= num_abs[32:0];
      end
      if (cmd.wr_tnext) begin
         tn_ff[cmd.axis] <= tq;
      end
      if (cmd.wr_tdelta) begin
         td_ff[cmd.axis] <= tq;
      end
      if (cmd.sat_corner) begin
         corner_ff[cmd.axis] <= sat_val;
      end
      if (cmd.advance) begin
         if (pre_ff) begin
            for (int a = 0; a < 3; a++) begin
               cur_ff[a] <= cur_ff[a] - {31'd0, diff_ff[a]};
            end
         end else begin
            cur_ff[ax_adv] <= neg_ff[ax_adv] ? cur_ff[ax_adv] - 32'd1
                                             : cur_ff[ax_adv] + 32'd1;
            tn_ff[ax_adv]  <= tsum[vrt_pkg::TW] ? vrt_pkg::TMAX
                                                : tsum[vrt_pkg::TW-1:0];
         end
      end
   end

   // result payload
   assign rsp_data.index_x   = cur_ff[0];
   assign rsp_data.index_y   = cur_ff[1];
   assign rsp_data.index_z   = cur_ff[2];
   assign rsp_data.corner_x  = corner_ff[0];
   assign rsp_data.corner_y  = corner_ff[1];
   assign rsp_data.corner_z  = corner_ff[2];
   assign rsp_data.last      = at_end || cap;
   assign rsp_data.truncated = !at_end && cap;

   assign status.div_busy = div_busy;
   assign status.last     = at_end || cap;

endmodule

@@ rtl/vrt_ctrl.sv @@
// ----------------------------------------------------------------------------
// vrt_ctrl: traversal controller
// Sequences per-axis setup divisions, then corner products and one result
// transfer per voxel.
// ----------------------------------------------------------------------------
module vrt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  vrt_pkg::status_type  status,
   output vrt_pkg::cmd_type     cmd
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_DIVS_GO   = 4'd1;
   localparam logic [3:0] ST_DIVS_WAIT = 4'd2;
   localparam logic [3:0] ST_DIVE_GO   = 4'd3;
   localparam logic [3:0] ST_DIVE_WAIT = 4'd4;
   localparam logic [3:0] ST_BND_MUL   = 4'd5;
   localparam logic [3:0] ST_BND_NUM   = 4'd6;
   localparam logic [3:0] ST_DIVN_GO   = 4'd7;
   localparam logic [3:0] ST_DIVN_WAIT = 4'd8;
   localparam logic [3:0] ST_DIVD_GO   = 4'd9;
   localparam logic [3:0] ST_DIVD_WAIT = 4'd10;
   localparam logic [3:0] ST_CMUL      = 4'd11;
   localparam logic [3:0] ST_CSAT      = 4'd12;
   localparam logic [3:0] ST_OUT       = 4'd13;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic [1:0] axis_ff;
   logic [1:0] axis_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      cmd      = '0;
      cmd.axis = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               axis_in  = 2'd0;
               state_in = ST_DIVS_GO;
            end
         end
         ST_DIVS_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = vrt_pkg::DSEL_START;
            state_in      = ST_DIVS_WAIT;
         end
         ST_DIVS_WAIT: begin
            cmd.div_sel = vrt_pkg::DSEL_START;
            if (!status.div_busy) begin
               cmd.wr_start_idx = 1'b1;
               state_in         = ST_DIVE_GO;
            end
         end
         ST_DIVE_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = vrt_pkg::DSEL_END;
            state_in      = ST_DIVE_WAIT;
         end
         ST_DIVE_WAIT: begin
            cmd.div_sel = vrt_pkg::DSEL_END;
            if (!status.div_busy) begin
               cmd.wr_end_idx = 1'b1;
               state_in       = ST_BND_MUL;
            end
         end
         ST_BND_MUL: begin
            cmd.mul_bound = 1'b1;
            state_in      = ST_BND_NUM;
         end
         ST_BND_NUM: begin
            cmd.calc_num = 1'b1;
            state_in     = ST_DIVN_GO;
         end
         ST_DIVN_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = vrt_pkg::DSEL_NEXT;
            state_in      = ST_DIVN_WAIT;
         end
         ST_DIVN_WAIT: begin
            cmd.div_sel = vrt_pkg::DSEL_NEXT;
            if (!status.div_busy) begin
               cmd.wr_tnext = 1'b1;
               state_in     = ST_DIVD_GO;
            end
         end
         ST_DIVD_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = vrt_pkg::DSEL_DELTA;
            state_in      = ST_DIVD_WAIT;
         end
         ST_DIVD_WAIT: begin
            cmd.div_sel = vrt_pkg::DSEL_DELTA;
            if (!status.div_busy) begin
               cmd.wr_tdelta = 1'b1;
               if (axis_ff == 2'd2) begin
                  axis_in  = 2'd0;
                  state_in = ST_CMUL;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = ST_DIVS_GO;
               end
            end
         end
         ST_CMUL: begin
            cmd.mul_corner = 1'b1;
            state_in       = ST_CSAT;
         end
         ST_CSAT: begin
            cmd.sat_corner = 1'b1;
            if (axis_ff == 2'd2) begin
               axis_in  = 2'd0;
               state_in = ST_OUT;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_CMUL;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (status.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  axis_in     = 2'd0;
                  state_in    = ST_CMUL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

endmodule

@@ rtl/voxel_ray_traversal_3d_top.sv @@
// ----------------------------------------------------------------------------
// voxel_ray_traversal_3d_top: grid walk of one ray through cubic voxels
// From ray transfer to first result: 12 serial divisions (launch, 65
// quotient bits, write-back), a boundary product and numerator step per
// axis, then corner products on the shared multiplier for each axis.
// Each further voxel repeats the corner products after the result is taken.
// One ray at a time; synchronous reset returns to idle, voxel size 6554.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_3d_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  vrt_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output vrt_pkg::rsp_type            rsp_data,
   input  logic                        csr_wr_en,
   input  logic [vrt_pkg::SIZE_W-1:0]  csr_wr_data
);

   vrt_pkg::cmd_type          cmd;
   vrt_pkg::status_type       status;
   logic                      div_start;
   logic [vrt_pkg::DVD_W-1:0] div_dividend;
   logic [vrt_pkg::DIV_W-1:0] div_divisor;
   logic                      div_busy;
   logic [vrt_pkg::DVD_W-1:0] div_quotient;
   logic                      div_rem_nz;

   // sequencer
   vrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   vrt_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_data     (req_data),
      .rsp_data     (rsp_data),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_busy     (div_busy),
      .div_quotient (div_quotient),
      .div_rem_nz   (div_rem_nz)
   );

   // shared serial divider
   vrt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quotient),
      .rem_nz   (div_rem_nz)
   );

endmodule

@@ rtl/vrt_checker.sv @@
// ----------------------------------------------------------------------------
// vrt_checker: port-level checks of the traversal block
// Watches the request and result channels over time.
// ----------------------------------------------------------------------------
module vrt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input vrt_pkg::rsp_type  rsp_data
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // no new ray while a result is pending
   a_busy_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken during result transfer");

   // truncation only on the final voxel
   a_trunc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.truncated |-> rsp_data.last)
      else $error("truncated without last");

   // setup follows an accepted ray
   a_setup_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid && req_stall)
      else $error("result right after request transfer");

endmodule

bind voxel_ray_traversal_3d_top vrt_checker u_vrt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
